/* sv/frame_pace_sleep_limiter_defines.svh */
// Assertion macros shared by the frame pace limiter RTL.
// All of them sample on clock and are switched off while reset is high.
`ifndef FRAME_PACE_SLEEP_LIMITER_DEFINES_SVH
`define FRAME_PACE_SLEEP_LIMITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPSL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/fpsl_pkg.sv */
`default_nettype none

package fpsl_pkg;

   localparam int ELAPSED_W = 40;
   localparam int COUNT_W   = 16;
   localparam int SLEEP_W   = 30;
   localparam int TARGET_W  = 8;

   localparam int HISTORY_DEPTH_DEF = 10;
   localparam int KEEP_COUNT_DEF    = 8;

   localparam logic [SLEEP_W-1:0] NS_PER_SECOND = 30'd1_000_000_000;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_THRESHOLD = 2'd0,
      CSR_HIGH_TARGET    = 2'd1,
      CSR_LOW_TARGET     = 2'd2,
      CSR_TRIMMED_MODE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] elapsed_ns;
      logic [COUNT_W-1:0]   client_count;
   } req_type;

   typedef struct packed {
      logic [SLEEP_W-1:0]   sleep_ns;
      logic                 sleep_valid;
      logic [ELAPSED_W-1:0] average_ns;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic push;
      logic sum_step;
      logic min_step;
      logic frame_start;
      logic avg_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic target_zero;
      logic trimmed;
      logic scan_last;
      logic need_trim;
      logic trim_last;
      logic frame_done;
      logic avg_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* sv/fpsl_divider.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module fpsl_divider #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, work_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         work_in = {work_ff[NUM_W-2:0], ge};
         rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign busy = busy_ff;
   assign quot = work_ff;

endmodule

`default_nettype wire

/* sv/fpsl_datapath.sv */
`default_nettype none

module fpsl_datapath #(
   parameter int HISTORY_DEPTH = fpsl_pkg::HISTORY_DEPTH_DEF,
   parameter int KEEP_COUNT    = fpsl_pkg::KEEP_COUNT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire fpsl_pkg::req_type                req_data,
   input  wire fpsl_pkg::cmd_type                cmd,
   output fpsl_pkg::status_type                  status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output fpsl_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [fpsl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fpsl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int EW     = fpsl_pkg::ELAPSED_W;
   localparam int SW     = fpsl_pkg::SLEEP_W;
   localparam int TW     = fpsl_pkg::TARGET_W;
   localparam int CW     = fpsl_pkg::COUNT_W;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int KEEP_W = $clog2(KEEP_COUNT + 1);
   localparam int SUM_W  = EW + CNT_W;

   // configuration
   logic [CW-1:0] thresh_ff, thresh_in;
   logic [TW-1:0] high_ff, high_in;
   logic [TW-1:0] low_ff, low_in;
   logic          trimmed_ff, trimmed_in;

   // item operands
   logic [EW-1:0] elapsed_ff, elapsed_in;
   logic [TW-1:0] target_ff, target_in;

   // history and trimming scan
   logic [EW-1:0]            hist_ff [HISTORY_DEPTH];
   logic [EW-1:0]            hist_in [HISTORY_DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [HISTORY_DEPTH-1:0] used_ff, used_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [EW-1:0]            min_val_ff, min_val_in;
   logic [IDX_W-1:0]         min_idx_ff, min_idx_in;
   logic                     have_ff, have_in;
   logic [CNT_W-1:0]         trim_left_ff, trim_left_in;

   // result stage
   logic                     rsp_valid_ff, rsp_valid_in;
   fpsl_pkg::rsp_type        rsp_ff, rsp_in;

   logic [EW-1:0]     cand;
   logic              scan_last;
   logic              take;
   logic [EW-1:0]     best_val;
   logic [IDX_W-1:0]  best_idx;
   logic              need_trim;
   logic [KEEP_W-1:0] keep;
   logic              frame_busy;
   logic              avg_busy;
   logic [SW-1:0]     frame_quot;
   logic [SUM_W-1:0]  avg_quot;
   logic [EW-1:0]     average;
   logic              fire;
   logic [SW-1:0]     sleep;

   assign cand      = hist_ff[idx_ff];
   assign scan_last = idx_ff == IDX_W'(count_ff - CNT_W'(1));
   assign take      = !used_ff[idx_ff] && (!have_ff || cand < min_val_ff);
   assign best_val  = take ? cand : min_val_ff;
   assign best_idx  = take ? idx_ff : min_idx_ff;
   assign need_trim = 32'(count_ff) > 32'(KEEP_COUNT);
   assign keep      = need_trim ? KEEP_W'(KEEP_COUNT) : KEEP_W'(count_ff);

   fpsl_divider #(
      .NUM_W (SW),
      .DEN_W (TW)
   ) u_frame_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.frame_start),
      .num   (fpsl_pkg::NS_PER_SECOND),
      .den   (target_ff),
      .busy  (frame_busy),
      .quot  (frame_quot)
   );

   fpsl_divider #(
      .NUM_W (SUM_W),
      .DEN_W (KEEP_W)
   ) u_avg_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.avg_start),
      .num   (sum_ff),
      .den   (keep),
      .busy  (avg_busy),
      .quot  (avg_quot)
   );

   always_comb begin
      thresh_in  = thresh_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      trimmed_in = trimmed_ff;
      if (csr_we) begin
         case (csr_index)
            fpsl_pkg::CSR_RATE_THRESHOLD: thresh_in  = csr_wdata[CW-1:0];
            fpsl_pkg::CSR_HIGH_TARGET:    high_in    = csr_wdata[TW-1:0];
            fpsl_pkg::CSR_LOW_TARGET:     low_in     = csr_wdata[TW-1:0];
            fpsl_pkg::CSR_TRIMMED_MODE:   trimmed_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      elapsed_in = elapsed_ff;
      target_in  = target_ff;
      if (cmd.load) begin
         elapsed_in = req_data.elapsed_ns;
         target_in  = (req_data.client_count >= thresh_ff) ? high_ff : low_ff;
      end
   end

   always_comb begin
      hist_in  = hist_ff;
      count_in = count_ff;
      if (cmd.push) begin
         // newest first, drop the oldest
         hist_in[0] = elapsed_ff;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
         if (count_ff != CNT_W'(HISTORY_DEPTH)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // Sum all valid entries, then remove the smallest ones one scan at a time.
   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      used_in      = used_ff;
      have_in      = have_ff;
      min_val_in   = min_val_ff;
      min_idx_in   = min_idx_ff;
      trim_left_in = trim_left_ff;
      if (cmd.push) begin
         idx_in  = '0;
         sum_in  = '0;
         used_in = '0;
         have_in = 1'b0;
      end else if (cmd.sum_step) begin
         sum_in = sum_ff + SUM_W'(cand);
         if (scan_last) begin
            idx_in       = '0;
            have_in      = 1'b0;
            trim_left_in = need_trim ? CNT_W'(count_ff - CNT_W'(KEEP_COUNT)) : '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end else if (cmd.min_step) begin
         if (scan_last) begin
            sum_in            = sum_ff - SUM_W'(best_val);
            used_in[best_idx] = 1'b1;
            trim_left_in      = trim_left_ff - CNT_W'(1);
            idx_in            = '0;
            have_in           = 1'b0;
         end else begin
            idx_in     = idx_ff + IDX_W'(1);
            min_val_in = best_val;
            min_idx_in = best_idx;
            have_in    = have_ff | take;
         end
      end
   end

   assign average = trimmed_ff ? avg_quot[EW-1:0] : elapsed_ff;
   assign fire    = (elapsed_ff < EW'(frame_quot)) && (average < EW'(frame_quot));
   assign sleep   = fire ? frame_quot - elapsed_ff[SW-1:0] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (target_ff == '0) begin
            rsp_in = '0;
         end else begin
            rsp_in.sleep_ns    = sleep;
            rsp_in.sleep_valid = sleep != '0;
            rsp_in.average_ns  = average;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         trimmed_ff   <= 1'b0;
         count_ff     <= '0;
         used_ff      <= '0;
         idx_ff       <= '0;
         have_ff      <= 1'b0;
         trim_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         trimmed_ff   <= trimmed_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         have_ff      <= have_in;
         trim_left_ff <= trim_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      target_ff  <= target_in;
      hist_ff    <= hist_in;
      sum_ff     <= sum_in;
      min_val_ff <= min_val_in;
      min_idx_ff <= min_idx_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      status.target_zero = target_ff == '0;
      status.trimmed     = trimmed_ff;
      status.scan_last   = scan_last;
      status.need_trim   = need_trim;
      status.trim_last   = trim_left_ff == CNT_W'(1);
      status.frame_done  = !frame_busy;
      status.avg_done    = !avg_busy;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* sv/fpsl_ctrl.sv */
`default_nettype none

module fpsl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fpsl_pkg::status_type status,
   output fpsl_pkg::cmd_type         cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_SUM  = 7'b0000100,
      S_TRIM = 7'b0001000,
      S_AVG  = 7'b0010000,
      S_WAIT = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (status.target_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.frame_start = 1'b1;
               if (status.trimmed) begin
                  cmd.push = 1'b1;
                  state_in = S_SUM;
               end else begin
                  state_in = S_WAIT;
               end
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.scan_last) begin
               state_in = status.need_trim ? S_TRIM : S_AVG;
            end
         end
         S_TRIM: begin
            cmd.min_step = 1'b1;
            if (status.scan_last && status.trim_last) begin
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            cmd.avg_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (status.frame_done && (status.avg_done || !status.trimmed)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

`default_nettype wire

/* sv/frame_pace_sleep_limiter.sv */
`default_nettype none
`include "frame_pace_sleep_limiter_defines.svh"

// Frame pace limiter: one request per frame tick, one response per request, in order.
// Items are handled one at a time; the next request is taken once the previous
// result sits in the response register, even if that result is not yet consumed.
// A tick whose selected target is zero skips both dividers. In plain mode the result
// waits on the serial division 1e9/target. In trimmed mode, with n valid history
// entries and K = KEEP_COUNT, the history is summed in one scan, the (n - K)
// smallest entries are removed with one scan of n entries each when n > K, then a
// serial divider of 40 + clog2(HISTORY_DEPTH + 1) quotient bits computes the average.
// Configuration writes take effect at once and should be issued only when idle.
module frame_pace_sleep_limiter #(
   parameter int HISTORY_DEPTH = fpsl_pkg::HISTORY_DEPTH_DEF,
   parameter int KEEP_COUNT    = fpsl_pkg::KEEP_COUNT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire fpsl_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output fpsl_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [fpsl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fpsl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fpsl_pkg::cmd_type    cmd;
   fpsl_pkg::status_type status;

   fpsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpsl_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .KEEP_COUNT    (KEEP_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   `FPSL_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "request taken while busy")
   `FPSL_ASSERT_SAME(a_out_free, cmd.out_load, status.out_free, "result overwrote pending response")
   `FPSL_ASSERT_SAME(a_frame_idle, cmd.frame_start, status.frame_done, "frame divider restarted")
   `FPSL_ASSERT_SAME(a_avg_idle, cmd.avg_start, status.avg_done, "average divider restarted")

endmodule

`default_nettype wire

/* verif/frame_pace_checker.sv */
`timescale 1ns / 100ps

module frame_pace_checker
   import fpsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    outstanding,
   output int                    mismatches,
   output int                    sleeps_seen
);

   localparam int DEPTH = HISTORY_DEPTH_DEF;
   localparam int KEEP  = KEEP_COUNT_DEF;
   localparam int MAX_REPORTS = 20;

   logic [COUNT_W-1:0]   threshold;
   logic [TARGET_W-1:0]  busy_hz;
   logic [TARGET_W-1:0]  quiet_hz;
   logic                 trimmed;
   logic [ELAPSED_W-1:0] history [DEPTH];
   int                   history_fill;

   rsp_type paced_results [$];
   rsp_type want;
   int      results_seen;

   function automatic rsp_type pace_tick(input req_type tick);
      rsp_type              r;
      logic [TARGET_W-1:0]  target;
      logic [ELAPSED_W-1:0] sorted [DEPTH];
      logic [ELAPSED_W-1:0] swap;
      logic [63:0]          total;
      logic [63:0]          average;
      logic [63:0]          frame;
      int                   keep;
      r = '0;
      target = (tick.client_count >= threshold) ? busy_hz : quiet_hz;
      if (target == 0)
         return r;
      if (trimmed) begin
         // push newest first, drop the oldest once full
         for (int i = DEPTH - 1; i > 0; i--)
            history[i] = history[i - 1];
         history[0] = tick.elapsed_ns;
         if (history_fill < DEPTH)
            history_fill++;
         for (int i = 0; i < history_fill; i++)
            sorted[i] = history[i];
         for (int i = 0; i < history_fill - 1; i++) begin
            for (int j = 0; j < history_fill - 1 - i; j++) begin
               if (sorted[j] < sorted[j + 1]) begin
                  swap = sorted[j];
                  sorted[j] = sorted[j + 1];
                  sorted[j + 1] = swap;
               end
            end
         end
         keep = (history_fill < KEEP) ? history_fill : KEEP;
         total = '0;
         for (int i = 0; i < keep; i++)
            total += 64'(sorted[i]);
         average = total / keep;
      end else begin
         average = 64'(tick.elapsed_ns);
      end
      frame = 64'd1_000_000_000 / target;
      if (64'(tick.elapsed_ns) < frame && average < frame)
         r.sleep_ns = SLEEP_W'(frame - 64'(tick.elapsed_ns));
      r.sleep_valid = (r.sleep_ns != 0);
      r.average_ns  = average[ELAPSED_W-1:0];
      return r;
   endfunction

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] exp_v);
      if (mismatches < MAX_REPORTS)
         $display("mismatch on result %0d, %s: got %0d, predicted %0d",
                  results_seen, field, got, exp_v);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold    = '0;
         busy_hz      = '0;
         quiet_hz     = '0;
         trimmed      = 1'b0;
         history_fill = 0;
         for (int i = 0; i < DEPTH; i++)
            history[i] = '0;
         paced_results.delete();
         results_seen = 0;
         mismatches   = 0;
         sleeps_seen  = 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RATE_THRESHOLD: threshold = csr_wdata[COUNT_W-1:0];
               CSR_HIGH_TARGET:    busy_hz   = csr_wdata[TARGET_W-1:0];
               CSR_LOW_TARGET:     quiet_hz  = csr_wdata[TARGET_W-1:0];
               CSR_TRIMMED_MODE:   trimmed   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            paced_results.push_back(pace_tick(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.sleep_valid)
               sleeps_seen++;
            if (paced_results.size() == 0) begin
               report("unexpected transfer", 64'(rsp_data.sleep_ns), 64'd0);
            end else begin
               want = paced_results.pop_front();
               if (rsp_data.sleep_ns !== want.sleep_ns)
                  report("sleep_ns", 64'(rsp_data.sleep_ns), 64'(want.sleep_ns));
               if (rsp_data.sleep_valid !== want.sleep_valid)
                  report("sleep_valid", 64'(rsp_data.sleep_valid), 64'(want.sleep_valid));
               if (rsp_data.average_ns !== want.average_ns)
                  report("average_ns", 64'(rsp_data.average_ns), 64'(want.average_ns));
            end
            results_seen++;
         end
         outstanding <= paced_results.size();
      end
   end

endmodule

/* verif/tb_frame_pace_sleep_limiter.sv */
`timescale 1ns / 100ps

module tb_frame_pace_sleep_limiter;
   import fpsl_pkg::*;

   localparam int CYCLE_LIMIT     = 600_000;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_TICKS     = 104;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 100;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int outstanding;
   int mismatches;
   int sleeps_seen;

   // stimulus side copy of the registers, used only to aim elapsed times and client counts
   logic [COUNT_W-1:0]  cfg_threshold = '0;
   logic [TARGET_W-1:0] cfg_high      = '0;
   logic [TARGET_W-1:0] cfg_low       = '0;

   bit quiet          = 1'b0;
   int hold_off       = 0;
   int cycles         = 0;
   int ticks_sent     = 0;
   int settings_used  = 0;

   frame_pace_sleep_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_pace_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches),
      .sleeps_seen (sleeps_seen)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
         $display("FAIL frame_pace_sleep_limiter");
         $finish;
      end
   end

   task automatic configure(input logic [15:0] thr, input logic [15:0] hi,
                            input logic [15:0] lo, input logic [15:0] mode);
      csr_we    <= 1'b1;
      csr_index <= CSR_RATE_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CSR_HIGH_TARGET;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_LOW_TARGET;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_TRIMMED_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_threshold = thr;
      cfg_high      = hi[TARGET_W-1:0];
      cfg_low       = lo[TARGET_W-1:0];
      settings_used++;
   endtask

   task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed, input logic [COUNT_W-1:0] count);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {elapsed, count};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
   endtask

   // drop valid and hold until every predicted result has been transferred
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return cfg_threshold;
         3: return cfg_threshold - 1'b1;
         4: return cfg_threshold + 1'b1;
         default: return COUNT_W'($urandom);
      endcase
   endfunction

   // mostly near the frame time of the selected target, where sleeps are decided
   function automatic logic [ELAPSED_W-1:0] pick_elapsed(input logic [COUNT_W-1:0] count);
      logic [TARGET_W-1:0] target;
      logic [63:0]         frame;
      logic [63:0]         wide;
      target = (count >= cfg_threshold) ? cfg_high : cfg_low;
      frame  = (target == 0) ? 64'd16_666_666 : 64'd1_000_000_000 / target;
      wide   = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0: return '0;
         1: return '1;
         2: return wide[ELAPSED_W-1:0];
         3: return ELAPSED_W'(frame - 1);
         4: return ELAPSED_W'(frame);
         5: return ELAPSED_W'(frame + 1);
         6: return ELAPSED_W'($urandom_range(0, 999));
         default: return ELAPSED_W'(frame * $urandom_range(40, 125) / 100);
      endcase
   endfunction

   function automatic logic [15:0] pick_target_write();
      logic [7:0] t;
      t = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      // upper byte is noise that the register must drop
      return {8'($urandom), t};
   endfunction

   task automatic choose_settings(input int p);
      logic [15:0] thr;
      logic [15:0] hi;
      logic [15:0] lo;
      logic [15:0] mode;
      case (p % 4)
         0: thr = 16'h0000;
         1: thr = 16'hFFFF;
         default: thr = 16'($urandom);
      endcase
      hi = pick_target_write();
      lo = pick_target_write();
      if (p == 0) begin
         hi = 16'h00FF;
         lo = 16'h0001;
      end else if (p == 1) begin
         hi = 16'h0001;
         lo = 16'h00FF;
      end
      mode = {15'($urandom), 1'(p % 3 != 2)};
      configure(thr, hi, lo, mode);
   endtask

   // receiver: random stall per result, plus one long hold-off on request
   initial begin
      int stall;
      forever begin
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         stall = quiet ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [COUNT_W-1:0] count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // trimmed mode: extremes, frame boundary, then fill and overflow the history
      configure(16'd100, 16'd60, 16'd30, 16'd1);
      send_tick(40'd0, 16'd100);
      send_tick(40'hFF_FFFF_FFFF, 16'hFFFF);
      send_tick(40'd16_666_665, 16'd100);
      send_tick(40'd16_666_666, 16'd99);
      send_tick(40'd1000, 16'd0);
      for (int i = 0; i < 7; i++)
         send_tick(40'd5_000_000 + 40'(i) * 40'd1_000_000, 16'd100 + 16'(i));
      drain();

      // plain mode with oversized register writes, slowest and fastest targets
      configure(16'hFFFF, 16'hFF01, 16'h00FF, 16'hFFFE);
      send_tick(40'd999_999_999, 16'hFFFF);
      send_tick(40'd1_000_000_000, 16'hFFFF);
      send_tick(40'd3_921_567, 16'd0);
      send_tick(40'd0, 16'hFFFE);
      drain();

      // zero target must leave the history alone
      configure(16'd50, 16'd200, 16'd0, 16'h0003);
      send_tick(40'd123, 16'd10);
      send_tick(40'hFF_FFFF_FFFF, 16'd0);
      send_tick(40'd4_000_000, 16'd50);
      send_tick(40'd5, 16'd49);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         choose_settings(p);
         quiet = (p == 3 || p == 8);
         if (p == 2)
            hold_off = HOLD_OFF_CYCLES;
         for (int k = 0; k < PHASE_TICKS; k++) begin
            count = pick_count();
            send_tick(pick_elapsed(count), count);
         end
         drain();
      end
      quiet = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d ticks under %0d register settings; %0d results asked for a sleep",
               ticks_sent, settings_used, sleeps_seen);
      $display("receiver held off %0d cycles once; two phases ran with no gaps on either side",
               HOLD_OFF_CYCLES);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS frame_pace_sleep_limiter");
      else
         $display("FAIL frame_pace_sleep_limiter");
      $finish;
   end

endmodule
